### hw/rtl/ttmt_pkg.sv
// ----------------------------------------------------------------------------
// ttmt_pkg
// Shared types and codes of the two-tier id/class match table.
// ----------------------------------------------------------------------------
package ttmt_pkg;

  localparam int KEY_W   = 32;
  localparam int CLASS_W = 16;
  localparam int TAG_W   = 16;

  // Request codes
  localparam logic [1:0] REQ_INSERT_EXACT = 2'd0;
  localparam logic [1:0] REQ_INSERT_CLASS = 2'd1;
  localparam logic [1:0] REQ_LOOKUP       = 2'd2;

  // Status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MATCH    = 2'd2;
  localparam logic [1:0] ST_NO_MATCH = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [KEY_W-1:0]   device_key;
    logic [CLASS_W-1:0] class_key;
    logic [TAG_W-1:0]   handler_tag;
  } in_payload_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TAG_W-1:0] found_handler;
  } out_payload_t;

  typedef struct packed {
    logic             is_exact;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] handler;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic insert;
    logic scan_start;
    logic scan_run;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_insert;
    logic is_lookup;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

### hw/rtl/ttmt_if.sv
// ----------------------------------------------------------------------------
// ttmt_if
// Valid/ready channels for requests and responses of the match table.
// ----------------------------------------------------------------------------
interface ttmt_req_if;
  logic                 valid;
  logic                 ready;
  ttmt_pkg::in_payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ttmt_rsp_if;
  logic                  valid;
  logic                  ready;
  ttmt_pkg::out_payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/ttmt_ram.sv
// ----------------------------------------------------------------------------
// ttmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ttmt_ctrl.sv
// ----------------------------------------------------------------------------
// ttmt_ctrl
// Sequencer of the match table: accept, dispatch, scan and respond.
// ----------------------------------------------------------------------------
module ttmt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ttmt_pkg::stat_t stat,
  output ttmt_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DISPATCH = 4'b0010,
    S_SCAN     = 4'b0100,
    S_DONE     = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_insert) begin
          cmd.insert = 1'b1;
          state_next = S_DONE;
        end else if (stat.is_lookup) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hw/rtl/ttmt_dp.sv
// ----------------------------------------------------------------------------
// ttmt_dp
// Datapath: request register, entry RAM, scan counters and output register.
// ----------------------------------------------------------------------------
module ttmt_dp #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ttmt_pkg::in_payload_t  req_data,
  input  ttmt_pkg::cmd_t         cmd,
  output ttmt_pkg::stat_t        stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output ttmt_pkg::out_payload_t out_data
);

  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int ENTRY_W = $bits(ttmt_pkg::entry_t);

  logic [1:0]                   req_type;
  logic [ttmt_pkg::KEY_W-1:0]   dkey;
  logic [ttmt_pkg::CLASS_W-1:0] ckey;
  logic [ttmt_pkg::TAG_W-1:0]   tag;

  logic [CNT_W-1:0]             count;
  logic [1:0]                   ins_status;
  logic [CNT_W-1:0]             issue_cnt;
  logic                         pend;
  logic                         have_exact;
  logic                         have_class;
  logic [ttmt_pkg::TAG_W-1:0]   exact_h;
  logic [ttmt_pkg::TAG_W-1:0]   class_h;

  logic                         full;
  logic                         is_exact_req;
  logic                         we;
  ttmt_pkg::entry_t             wr_entry;
  logic                         re;
  logic                         issue_more;
  logic [ENTRY_W-1:0]           rdata;
  ttmt_pkg::entry_t             rd_entry;
  logic [1:0]                   res_status;
  logic [ttmt_pkg::TAG_W-1:0]   res_handler;

  assign full         = (count == CNT_W'(MAX_ENTRIES));
  assign is_exact_req = (req_type == ttmt_pkg::REQ_INSERT_EXACT);
  assign issue_more   = (issue_cnt != count);

  assign we                = cmd.insert && !full;
  assign wr_entry.is_exact = is_exact_req;
  assign wr_entry.key      = is_exact_req ? dkey
                                          : {{(ttmt_pkg::KEY_W - ttmt_pkg::CLASS_W){1'b0}}, ckey};
  assign wr_entry.handler  = tag;

  assign re       = cmd.scan_run && issue_more;
  assign rd_entry = ttmt_pkg::entry_t'(rdata);

  ttmt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(count[IDX_W-1:0]),
    .wdata(wr_entry),
    .re   (re),
    .raddr(issue_cnt[IDX_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type <= req_data.req_type;
      dkey     <= req_data.device_key;
      ckey     <= req_data.class_key;
      tag      <= req_data.handler_tag;
    end
    if (cmd.insert) begin
      ins_status <= full ? ttmt_pkg::ST_FULL : ttmt_pkg::ST_INSERTED;
    end
    if (cmd.load_out) begin
      out_data.status        <= res_status;
      out_data.found_handler <= res_handler;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      issue_cnt  <= '0;
      pend       <= 1'b0;
      have_exact <= 1'b0;
      have_class <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (we) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        issue_cnt  <= '0;
        pend       <= 1'b0;
        have_exact <= 1'b0;
        have_class <= 1'b0;
      end else if (cmd.scan_run) begin
        if (issue_more) begin
          issue_cnt <= issue_cnt + CNT_W'(1);
        end
        pend <= issue_more;
        // keep only the earliest match of each kind
        if (pend) begin
          if (rd_entry.is_exact) begin
            if (!have_exact && rd_entry.key == dkey) begin
              have_exact <= 1'b1;
              exact_h    <= rd_entry.handler;
            end
          end else if (!have_class &&
                       rd_entry.key == {{(ttmt_pkg::KEY_W - ttmt_pkg::CLASS_W){1'b0}}, ckey}) begin
            have_class <= 1'b1;
            class_h    <= rd_entry.handler;
          end
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    res_status  = ttmt_pkg::ST_NO_MATCH;
    res_handler = '0;
    if (req_type == ttmt_pkg::REQ_LOOKUP) begin
      if (have_exact) begin
        res_status  = ttmt_pkg::ST_MATCH;
        res_handler = exact_h;
      end else if (have_class) begin
        res_status  = ttmt_pkg::ST_MATCH;
        res_handler = class_h;
      end
    end else if (stat.is_insert) begin
      res_status = ins_status;
    end
  end

  assign stat.is_insert = (req_type == ttmt_pkg::REQ_INSERT_EXACT) ||
                          (req_type == ttmt_pkg::REQ_INSERT_CLASS);
  assign stat.is_lookup = (req_type == ttmt_pkg::REQ_LOOKUP);
  assign stat.scan_done = !issue_more;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

### hw/rtl/two_tier_id_class_match_table.sv
// ----------------------------------------------------------------------------
// two_tier_id_class_match_table
// Append-only table of exact device-id and class entries with a two-tier
// lookup.
// ----------------------------------------------------------------------------
// Usage:
//   request  - valid/ready channel of req_type, device_key, class_key and
//              handler_tag. One item is in work at a time; ready is high only
//              while the block is idle.
//   response - valid/ready channel of status and found_handler, one item per
//              request, in request order.
// Sequence: an insert, or an unused request code, passes from accept through
//   the dispatch and done states back to idle; a lookup also passes through
//   the scan state, which streams the n stored entries out of the single-read
//   entry RAM, one a cycle, and keeps the earliest exact and the earliest
//   class match in one pass.
// Stall: the response sits in an output register; a new request is still
//   accepted while it waits, and the following result holds inside the block
//   until that register is taken.
// Reset: clears the entry count and the handshake state; the entry RAM is
//   not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module two_tier_id_class_match_table #(
  parameter int MAX_ENTRIES = 32
) (
  input logic        clk,
  input logic        rst,
  ttmt_req_if.sink   request,
  ttmt_rsp_if.source response
);

  ttmt_pkg::cmd_t  cmd;
  ttmt_pkg::stat_t stat;
  logic            in_ready;

  assign request.ready = in_ready;

  ttmt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(request.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ttmt_dp #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (request.data),
    .cmd      (cmd),
    .stat     (stat),
    .out_ready(response.ready),
    .out_valid(response.valid),
    .out_data (response.data)
  );

endmodule

### hw/rtl/ttmt_checker.sv
// ----------------------------------------------------------------------------
// ttmt_checker
// Port-level checks of the match table, bound to the top level.
// ----------------------------------------------------------------------------
module ttmt_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input ttmt_pkg::in_payload_t  req_data,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input ttmt_pkg::out_payload_t rsp_data
);

  logic req_fire;
  logic req_is_insert;

  assign req_fire      = req_valid && req_ready;
  assign req_is_insert = (req_data.req_type == ttmt_pkg::REQ_INSERT_EXACT) ||
                         (req_data.req_type == ttmt_pkg::REQ_INSERT_CLASS);

  // a stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // one item in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("request accepted while busy");

  // an insert with a free output answers with an inserted or full status
  a_insert_latency: assert property (@(posedge clk) disable iff (rst)
    req_fire && req_is_insert && !rsp_valid |-> ##3
      (rsp_valid && (rsp_data.status == ttmt_pkg::ST_INSERTED ||
                     rsp_data.status == ttmt_pkg::ST_FULL)))
    else $error("insert response missing or wrong status");

  // only a match carries a handler
  a_handler_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ttmt_pkg::ST_MATCH |-> rsp_data.found_handler == '0)
    else $error("nonzero handler without a match");

endmodule

bind two_tier_id_class_match_table ttmt_checker u_ttmt_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(request.valid),
  .req_ready(request.ready),
  .req_data (request.data),
  .rsp_valid(response.valid),
  .rsp_ready(response.ready),
  .rsp_data (response.data)
);

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-tier id/class match table. A queue-fed
// driver sends insert, lookup and unused-code requests, and a shadow copy of
// the table predicts each response. The monitor compares every response with
// the oldest prediction. The run steps through idle and stall patterns, one
// long response hold-off and a full table.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 32;
  localparam int PHASE_ITEMS = 283;
  localparam int HOLD_CYCLES = 400;
  localparam int KEY_W      = ttmt_pkg::KEY_W;
  localparam int CLASS_W    = ttmt_pkg::CLASS_W;
  localparam int TAG_W      = ttmt_pkg::TAG_W;

  // request code that the block does not define
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk;
  logic rst;

  ttmt_req_if req_ch ();
  ttmt_rsp_if rsp_ch ();

  two_tier_id_class_match_table #(
    .MAX_ENTRIES(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .request(req_ch.sink),
    .response(rsp_ch.source)
  );

  // Shadow copy of the table
  logic [KEY_W-1:0] shadow_key [DEPTH];
  logic             shadow_exact [DEPTH];
  logic [TAG_W-1:0] shadow_tag [DEPTH];
  int               shadow_count = 0;

  ttmt_pkg::in_payload_t  pending_reqs [$];
  ttmt_pkg::out_payload_t due_rsps [$];

  // Keys handed out by the stimulus, reused to hit stored entries
  logic [KEY_W-1:0]   used_dev_keys [$];
  logic [CLASS_W-1:0] used_class_keys [$];
  int                 inserts_made = 0;

  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   phase_id  = 0;
  logic hold_rsp  = 1'b0;

  int fail_count = 0;
  int n_sent = 0;
  int n_inserted = 0;
  int n_full = 0;
  int n_match = 0;
  int n_miss = 0;

  // Apply one request to the shadow table and return its response.
  function automatic ttmt_pkg::out_payload_t apply_request(ttmt_pkg::in_payload_t rq);
    ttmt_pkg::out_payload_t rsp;
    bit                     hit_exact;
    bit                     hit_class;
    logic [TAG_W-1:0]       exact_tag;
    logic [TAG_W-1:0]       class_tag;
    rsp.status        = ttmt_pkg::ST_NO_MATCH;
    rsp.found_handler = '0;
    hit_exact = 1'b0;
    hit_class = 1'b0;
    exact_tag = '0;
    class_tag = '0;
    case (rq.req_type)
      ttmt_pkg::REQ_INSERT_EXACT, ttmt_pkg::REQ_INSERT_CLASS: begin
        if (shadow_count >= DEPTH) begin
          rsp.status = ttmt_pkg::ST_FULL;
        end else begin
          shadow_exact[shadow_count] = (rq.req_type == ttmt_pkg::REQ_INSERT_EXACT);
          shadow_key[shadow_count]   = (rq.req_type == ttmt_pkg::REQ_INSERT_EXACT) ?
                                       rq.device_key : KEY_W'(rq.class_key);
          shadow_tag[shadow_count]   = rq.handler_tag;
          shadow_count++;
          rsp.status = ttmt_pkg::ST_INSERTED;
        end
      end
      ttmt_pkg::REQ_LOOKUP: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_exact[i]) begin
            if (!hit_exact && shadow_key[i] == rq.device_key) begin
              hit_exact = 1'b1;
              exact_tag = shadow_tag[i];
            end
          end else if (!hit_class && shadow_key[i] == KEY_W'(rq.class_key)) begin
            hit_class = 1'b1;
            class_tag = shadow_tag[i];
          end
        end
        if (hit_exact) begin
          rsp.status        = ttmt_pkg::ST_MATCH;
          rsp.found_handler = exact_tag;
        end else if (hit_class) begin
          rsp.status        = ttmt_pkg::ST_MATCH;
          rsp.found_handler = class_tag;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic ttmt_pkg::in_payload_t make_req(logic [1:0] kind,
                                                     logic [KEY_W-1:0] dev,
                                                     logic [CLASS_W-1:0] cls,
                                                     logic [TAG_W-1:0] tag);
    ttmt_pkg::in_payload_t rq;
    rq.req_type    = kind;
    rq.device_key  = dev;
    rq.class_key   = cls;
    rq.handler_tag = tag;
    return rq;
  endfunction

  // Mostly lookups that hit stored keys; inserts are frequent for the first 40 insert
  // requests, then rarer; once the table has filled they only exercise the full-table rejection.
  function automatic ttmt_pkg::in_payload_t random_request();
    ttmt_pkg::in_payload_t rq;
    int                    pick;
    int                    ins_pct;
    int                    sel;
    ins_pct = (inserts_made < 40) ? 30 : 8;
    pick    = $urandom_range(99);
    rq = make_req(ttmt_pkg::REQ_LOOKUP, KEY_W'($urandom), CLASS_W'($urandom),
                  TAG_W'($urandom));
    if ($urandom_range(19) == 0) begin
      rq.handler_tag = '0;
    end
    if (pick < ins_pct) begin
      inserts_made++;
      sel = $urandom_range(9);
      if ($urandom_range(1) == 0) begin
        rq.req_type = ttmt_pkg::REQ_INSERT_EXACT;
        if (sel < 3) begin
          rq.device_key = KEY_W'($urandom_range(15));
        end else if (sel < 6 && used_dev_keys.size() != 0) begin
          rq.device_key = used_dev_keys[$urandom_range(used_dev_keys.size() - 1)];
        end
        used_dev_keys.push_back(rq.device_key);
      end else begin
        rq.req_type = ttmt_pkg::REQ_INSERT_CLASS;
        if (sel < 3) begin
          rq.class_key = CLASS_W'($urandom_range(15));
        end else if (sel < 6 && used_class_keys.size() != 0) begin
          rq.class_key = used_class_keys[$urandom_range(used_class_keys.size() - 1)];
        end
        used_class_keys.push_back(rq.class_key);
      end
    end else if (pick < ins_pct + 4) begin
      rq.req_type = REQ_UNUSED;
    end else begin
      sel = $urandom_range(9);
      if (sel < 5 && used_dev_keys.size() != 0) begin
        rq.device_key = used_dev_keys[$urandom_range(used_dev_keys.size() - 1)];
      end else if (sel == 5 && used_class_keys.size() != 0) begin
        rq.device_key = KEY_W'(used_class_keys[$urandom_range(used_class_keys.size() - 1)]);
      end else if (sel == 6) begin
        rq.device_key = KEY_W'($urandom_range(15));
      end
      sel = $urandom_range(9);
      if (sel < 5 && used_class_keys.size() != 0) begin
        rq.class_key = used_class_keys[$urandom_range(used_class_keys.size() - 1)];
      end else if (sel == 5 && used_dev_keys.size() != 0) begin
        rq.class_key = CLASS_W'(used_dev_keys[$urandom_range(used_dev_keys.size() - 1)]);
      end else if (sel == 6) begin
        rq.class_key = CLASS_W'($urandom_range(15));
      end
    end
    return rq;
  endfunction

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    fork
      forever #10 clk = ~clk;
      begin
        repeat (2) @(posedge clk);
        rst <= 1'b0;
      end
    join
  end

  // Driver: hold an offered item until taken, predict it at acceptance.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        due_rsps.push_back(apply_request(req_ch.data));
        n_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 &&
            !(idle_pct != 0 && $urandom_range(99) < idle_pct)) begin
          req_ch.data  <= pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken response against the oldest prediction.
  always @(posedge clk) begin
    ttmt_pkg::out_payload_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_rsps.size() == 0) begin
          $error("response with no request outstanding: status %0d handler %0h",
                 rsp_ch.data.status, rsp_ch.data.found_handler);
          fail_count++;
        end else begin
          want = due_rsps.pop_front();
          if (rsp_ch.data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.data.status);
            fail_count++;
          end
          if (rsp_ch.data.found_handler !== want.found_handler) begin
            $error("found_handler: expected %0h, got %0h",
                   want.found_handler, rsp_ch.data.found_handler);
            fail_count++;
          end
          case (want.status)
            ttmt_pkg::ST_INSERTED: n_inserted++;
            ttmt_pkg::ST_FULL:     n_full++;
            ttmt_pkg::ST_MATCH:    n_match++;
            default:               n_miss++;
          endcase
        end
      end
      rsp_ch.ready <= !hold_rsp && !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  // Long response hold-off while the sender keeps offering items.
  initial begin
    wait (phase_id == 2);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || due_rsps.size() != 0 || req_ch.valid) begin
      @(negedge clk);
    end
  endtask

  initial begin
    wait (rst == 1'b0);
    @(negedge clk);

    // Directed: empty table, unused code, extremes, duplicates, tier order
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_LOOKUP, '0, '0, '0));
    pending_reqs.push_back(make_req(REQ_UNUSED, 32'h1357_9bdf, 16'h2468, 16'h0ace));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_INSERT_EXACT, '1, '0, 16'hffff));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_INSERT_EXACT, '0, '1, 16'h0000));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_INSERT_CLASS, '1, 16'hffff, 16'h1111));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_INSERT_CLASS, '0, 16'h0000, 16'haaaa));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_INSERT_CLASS, 32'h0, 16'h1234, 16'h5555));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_INSERT_EXACT, 32'h0000_1234, 16'h0,
                                    16'h2222));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_INSERT_EXACT, '1, '0, 16'h3333));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_INSERT_CLASS, '0, 16'hffff, 16'h4444));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_LOOKUP, '1, 16'hffff, '0));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_LOOKUP, '0, 16'h1234, '1));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_LOOKUP, 32'h1234_5678, 16'hffff, '0));
    // class entry key must not answer a device-id compare
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_LOOKUP, 32'h0000_ffff, 16'h0001, '0));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_LOOKUP, 32'h0000_1234, 16'h0000, '0));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_LOOKUP, 32'hdead_beef, 16'h1234, '0));
    pending_reqs.push_back(make_req(ttmt_pkg::REQ_LOOKUP, 32'h0000_1234, 16'hbeef, '0));
    pending_reqs.push_back(make_req(REQ_UNUSED, '1, '1, '1));
    used_dev_keys   = '{32'hffff_ffff, 32'h0, 32'h0000_1234};
    used_class_keys = '{16'hffff, 16'h0000, 16'h1234};
    inserts_made = 8;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      phase_id = ph;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // in every phase but the first, let the first 40 items drain before the rest
        if (k == 40 && ph != 0) begin
          drain();
        end
        pending_reqs.push_back(random_request());
      end
      // sender waits for every outstanding response before moving on
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (50) @(negedge clk);
    $display("Sent %0d requests: %0d inserted, %0d rejected on a full table,",
             n_sent, n_inserted, n_full);
    $display("%0d lookups matched, %0d answered no match (incl. unused codes)",
             n_match, n_miss);
    if (fail_count == 0 && due_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
